### hdl/crcc_pkg.sv
package crcc_pkg;

  localparam int unsigned WORD_BYTES_DEF = 8;
  localparam int unsigned DATA_W         = 64;
  localparam int unsigned CNT_W          = 4;
  localparam int unsigned CRC_W          = 32;
  localparam int unsigned LEN_W          = 32;

  localparam logic [CRC_W-1:0] CRC32C_POLY = 32'h82F6_3B78;
  localparam logic [CRC_W-1:0] CRC_INIT    = 32'hFFFF_FFFF;
  localparam logic [LEN_W-1:0] LEN_MAX     = 32'hFFFF_FFFF;

  // item kinds carried in req_type
  localparam logic REQ_HEADER  = 1'b0;
  localparam logic REQ_PAYLOAD = 1'b1;

  // control half of a registered beat, handed to the fold logic
  typedef struct packed {
    logic             is_payload;
    logic [CNT_W-1:0] byte_count;
  } fold_ctl_t;

  // running state of one record
  typedef struct packed {
    logic [CRC_W-1:0] crc;
    logic [LEN_W-1:0] len;
  } rec_state_t;

  // one reflected crc-32c byte step
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                input logic [7:0]       data);
    logic [CRC_W-1:0] c;
    c = crc_in ^ {24'd0, data};
    for (int b = 0; b < 8; b++) begin
      c = (c >> 1) ^ (CRC32C_POLY & {CRC_W{c[0]}});
    end
    return c;
  endfunction

endpackage

### hdl/crcc_fold.sv
module crcc_fold import crcc_pkg::*; #(
  parameter int unsigned WORD_BYTES = WORD_BYTES_DEF
) (
  input  rec_state_t        state_in,
  input  fold_ctl_t         ctl,
  input  logic [DATA_W-1:0] data_word,
  output rec_state_t        state_out
);

  localparam logic [CNT_W-1:0] WB = CNT_W'(WORD_BYTES);

  logic [CNT_W-1:0] n_bytes;
  logic [CRC_W-1:0] crc_v;
  logic [LEN_W:0]   len_sum;

  // header words always fold a full word, payload count is clamped
  always_comb begin
    if (ctl.is_payload == REQ_PAYLOAD) begin
      n_bytes = (ctl.byte_count > WB) ? WB : ctl.byte_count;
    end else begin
      n_bytes = WB;
    end
  end

  always_comb begin
    crc_v = state_in.crc;
    for (int i = 0; i < WORD_BYTES; i++) begin
      if (CNT_W'(i) < n_bytes) begin
        crc_v = crc_byte(crc_v, data_word[8*i +: 8]);
      end
    end
  end

  assign len_sum = {1'b0, state_in.len} + {{(LEN_W+1-CNT_W){1'b0}}, n_bytes};

  always_comb begin
    state_out.crc = crc_v;
    if (ctl.is_payload == REQ_PAYLOAD) begin
      state_out.len = len_sum[LEN_W] ? LEN_MAX : len_sum[LEN_W-1:0];
    end else begin
      state_out.len = state_in.len;
    end
  end

endmodule

### hdl/crc32c_record_checksum.sv
// channel | ports                                                  | beat moves
// in      | in_valid in_ready in_req_type in_data_word             | one header word or
//         | in_byte_count in_last_chunk                            | payload chunk
// out     | out_valid out_ready out_crc_value out_payload_bytes    | one record checksum
//
// one beat accepted per cycle while no last beat waits behind an untaken result; the
// crc loop closes through the byte-wide xor network in crcc_fold
// result: last beat is registered in the input stage, then its result in the result slot
// reset: synchronous active-low rst_n clears valids, crc to all ones, count to zero
// stalls: only a last beat waiting behind an untaken result holds the input
// register; every other beat keeps moving while a result waits
module crc32c_record_checksum import crcc_pkg::*; #(
  parameter int unsigned WORD_BYTES = WORD_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_req_type,
  input  logic [DATA_W-1:0] in_data_word,
  input  logic [CNT_W-1:0]  in_byte_count,
  input  logic              in_last_chunk,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CRC_W-1:0]  out_crc_value,
  output logic [LEN_W-1:0]  out_payload_bytes
);

  // input register stage
  logic              s0_valid_r;
  fold_ctl_t         s0_ctl_r;
  logic [DATA_W-1:0] s0_data_r;
  logic              s0_last_r;

  // running record state
  rec_state_t        rec_r;
  rec_state_t        rec_nxt;

  // result register
  logic              out_valid_r;
  logic [CRC_W-1:0]  out_crc_r;
  logic [LEN_W-1:0]  out_len_r;

  logic              s0_adv;
  logic              close;

  // the staged beat folds in unless it closes a record while an untaken result waits
  assign s0_adv   = s0_valid_r && !(s0_last_r && out_valid_r && !out_ready);
  assign close    = s0_adv && s0_last_r;
  assign in_ready = !s0_valid_r || s0_adv;

  crcc_fold #(
    .WORD_BYTES (WORD_BYTES)
  ) u_fold (
    .state_in  (rec_r),
    .ctl       (s0_ctl_r),
    .data_word (s0_data_r),
    .state_out (rec_nxt)
  );

  // input stage: control and payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_ready) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s0_ctl_r.is_payload <= in_req_type;
      s0_ctl_r.byte_count <= in_byte_count;
      s0_data_r           <= in_data_word;
      s0_last_r           <= in_last_chunk;
    end
  end

  // record state, back to reset value once a record closes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r.crc <= CRC_INIT;
      rec_r.len <= '0;
    end else if (close) begin
      rec_r.crc <= CRC_INIT;
      rec_r.len <= '0;
    end else if (s0_adv) begin
      rec_r <= rec_nxt;
    end
  end

  // result slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (close) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (close) begin
      out_crc_r <= ~rec_nxt.crc;
      out_len_r <= rec_nxt.len;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_crc_value     = out_crc_r;
  assign out_payload_bytes = out_len_r;

  // a closed record leaves the running state at its reset value
  a_close_resets: assert property (@(posedge clk) disable iff (!rst_n)
    close |=> (rec_r.crc == CRC_INIT) && (rec_r.len == '0))
    else $error("record state not restored after close");

  // the payload count never falls inside a record
  a_len_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (s0_adv && !s0_last_r) |=> (rec_r.len >= $past(rec_r.len)))
    else $error("payload count decreased inside a record");

  // a closing beat lands in the result slot
  a_close_valid: assert property (@(posedge clk) disable iff (!rst_n)
    close |=> out_valid_r)
    else $error("closed record produced no result");

  // an accepted beat is held in the input stage
  a_accept_staged: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> s0_valid_r)
    else $error("accepted beat lost");

endmodule
